// ===== hw/rtl/rgs_pkg.sv =====
// shared types and constants of the replicate group statistics block
package rgs_pkg;

  localparam int MAX_REPLICATES_DEF = 16;

  localparam logic [2:0] MODE_MEAN   = 3'd0;
  localparam logic [2:0] MODE_VAR    = 3'd1;
  localparam logic [2:0] MODE_MEDIAN = 3'd2;
  localparam logic [2:0] MODE_SD     = 3'd3;
  localparam logic [2:0] MODE_CV     = 3'd4;
  localparam logic [2:0] MODE_MIN    = 3'd5;
  localparam logic [2:0] MODE_MAX    = 3'd6;

  localparam logic [31:0] S32_MAX = 32'h7fff_ffff;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACC,
    OP_MED,
    OP_MUL_NS2,
    OP_MUL_S1SQ,
    OP_DIV_MEAN,
    OP_DIV_VAR,
    OP_DIV_SD,
    OP_SQRT,
    OP_MUL_CV,
    OP_DIV_CV,
    OP_RESULT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       ch;
    logic [2:0] mode;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic n_zero;
    logic all_eq;
    logic sum_zero;
  } sts_t;

endpackage

// ===== hw/rtl/replicate_group_statistics.sv =====
// top level of the replicate group statistics block
//
// input stream carries one replicate per transfer for channels a and b;
// tlast marks the last replicate of a sample, tuser flags missing values.
// values are stored per channel (up to MaxReplicates each, extras dropped).
// a transfer without tlast gives no result. on tlast the block stops
// accepting input and computes channel a then b, per channel: accumulate,
// then by statistic mean a divide, median a rank count per value, min/max
// nothing more, variance two multiplies and a divide, std deviation those
// and a root, cv also a multiply and a divide if the sum is not zero; an
// empty channel or, for variance, sd and cv, one with all values equal goes
// straight to the result step. the output register is written last; the
// multiplier and divider are shared and serial. one result transfer follows
// each sample. the output register holds a result until taken, while the
// next sample loads; a new result waits for that register to empty.
// reset clears the counts and selects the mean; config writes are taken
// at any time but are meant for when the block is idle.
module replicate_group_statistics #(
  parameter int MaxReplicates = rgs_pkg::MAX_REPLICATES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // value_a, value_b
  input  logic [1:0]  s_axis_tuser_i,  // a_missing, b_missing
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,  // stat_a, stat_b
  output logic [1:0]  m_axis_tuser_o,  // a_not_available, b_not_available
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);
  import rgs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic ld;
  logic [31:0] stat_a, stat_b;
  logic a_na, b_na;

  assign ld = s_axis_tvalid_i && s_axis_tready_o;

  rgs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_last_i    (s_axis_tlast_i),
    .s_ready_o   (s_axis_tready_o),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rgs_dp #(.MaxReplicates(MaxReplicates)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ld_i        (ld),
    .value_a_i   (s_axis_tdata_i[31:0]),
    .a_missing_i (s_axis_tuser_i[0]),
    .value_b_i   (s_axis_tdata_i[63:32]),
    .b_missing_i (s_axis_tuser_i[1]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .stat_a_o    (stat_a),
    .a_na_o      (a_na),
    .stat_b_o    (stat_b),
    .b_na_o      (b_na)
  );

  assign m_axis_tdata_o = {stat_b, stat_a};
  assign m_axis_tuser_o = {b_na, a_na};

endmodule

// ===== hw/rtl/rgs_dp.sv =====
// datapath: replicate stores, accumulators, shared multiply, divide and root units
module rgs_dp #(
  parameter int MaxReplicates = rgs_pkg::MAX_REPLICATES_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          ld_i,
  input  logic [31:0]   value_a_i,
  input  logic          a_missing_i,
  input  logic [31:0]   value_b_i,
  input  logic          b_missing_i,
  input  rgs_pkg::cmd_t cmd_i,
  output rgs_pkg::sts_t sts_o,
  output logic [31:0]   stat_a_o,
  output logic          a_na_o,
  output logic [31:0]   stat_b_o,
  output logic          b_na_o
);
  import rgs_pkg::*;

  localparam int AW   = $clog2(MaxReplicates);
  localparam int CW   = $clog2(MaxReplicates + 1);
  localparam int SW   = 33 + AW;
  localparam int WW   = 2 * SW;
  localparam int NUMW = WW + 1;
  localparam int DENW = (SW > 2 * AW + 16) ? SW : 2 * AW + 16;
  localparam int ITW  = $clog2(NUMW);

  logic [31:0] store_a [MaxReplicates];
  logic [31:0] store_b [MaxReplicates];
  logic [CW-1:0] cnt_a_q, cnt_b_q;
  logic wr_a, wr_b;
  logic [AW-1:0] rd_addr;
  logic [31:0] rda_q, rdb_q;

  logic scan_q, med_q, run_q, p1_q, p1_cand_q, p1_last_q, p2_q;
  logic [CW-1:0] j_q, i_q;
  op_e uop_q;
  logic [ITW-1:0] it_q;

  logic signed [31:0] x, x2_q, c_q, lo_q, hi_q, min_q, max_q;
  logic signed [63:0] sqr_q;
  logic signed [SW-1:0] s1_q;
  logic [WW-1:0] s2_q, acc_q, mc_q, d_q;
  logic [SW-1:0] mp_q;
  logic [CW-1:0] lt_q, le_q, lt_n, le_n;
  logic [NUMW-1:0] num_q, num_nx;
  logic [DENW-1:0] den_q;
  logic [DENW:0] rem_q, rem_sh, rem_nx;
  logic ge;
  logic [63:0] v_q, rt_q, bit_q, trial;
  logic [31:0] res_a_q, res_b_q, out_a_q, out_b_q;
  logic na_a_q, na_b_q, out_na_a_q, out_na_b_q;

  logic [CW-1:0] n, k1, k2, jm1;
  logic [2*CW-1:0] m;
  logic issue_acc, issue_med, s1_neg;
  logic [SW-1:0] s1_mag;
  logic [WW-1:0] dval;
  logic [32:0] sd_r, med_s, med_mag, med_h;
  logic [31:0] quo_sat, sd_sat, q32, res_v, med_v;
  logic res_na;

  assign wr_a = ld_i && !a_missing_i && (cnt_a_q < CW'(MaxReplicates));
  assign wr_b = ld_i && !b_missing_i && (cnt_b_q < CW'(MaxReplicates));
  assign n    = cmd_i.ch ? cnt_b_q : cnt_a_q;
  assign m    = (2*CW)'(n) * (2*CW)'(n - CW'(1));
  assign k1   = (n - CW'(1)) >> 1;
  assign k2   = n >> 1;
  assign jm1  = j_q - CW'(1);

  assign issue_acc = scan_q && (j_q < n);
  assign issue_med = med_q && (i_q < n);
  assign rd_addr   = med_q ? ((j_q == '0) ? i_q[AW-1:0] : jm1[AW-1:0]) : j_q[AW-1:0];
  assign x         = cmd_i.ch ? rdb_q : rda_q;

  assign lt_n = lt_q + CW'(x < c_q);
  assign le_n = le_q + CW'(x <= c_q);

  assign s1_neg = s1_q[SW-1];
  assign s1_mag = s1_neg ? SW'(-s1_q) : SW'(s1_q);
  assign dval   = d_q - acc_q;

  assign rem_sh = {rem_q[DENW-1:0], num_q[NUMW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};
  assign rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  assign num_nx = {num_q[NUMW-2:0], ge};
  assign trial  = rt_q + bit_q;

  // rounded root and final value selection
  assign sd_r    = (v_q > rt_q) ? rt_q[32:0] + 33'd1 : rt_q[32:0];
  assign sd_sat  = (|sd_r[32:31]) ? S32_MAX : sd_r[31:0];
  assign quo_sat = (|num_q[NUMW-1:31]) ? S32_MAX : num_q[31:0];
  assign q32     = num_q[31:0];
  assign med_s   = {lo_q[31], lo_q} + {hi_q[31], hi_q};
  assign med_mag = med_s[32] ? -med_s : med_s;
  assign med_h   = (med_mag + 33'd1) >> 1;
  assign med_v   = med_s[32] ? -med_h[31:0] : med_h[31:0];

  always_comb begin
    res_na = 1'b0;
    res_v  = '0;
    unique case (cmd_i.mode)
      MODE_MEAN:   res_v = s1_neg ? -q32 : q32;
      MODE_VAR:    begin res_na = (min_q == max_q); res_v = quo_sat; end
      MODE_MEDIAN: res_v = med_v;
      MODE_SD:     begin res_na = (min_q == max_q); res_v = sd_sat; end
      MODE_CV:     begin
        res_na = (min_q == max_q) || (s1_q == '0);
        res_v  = s1_neg ? -quo_sat : quo_sat;
      end
      MODE_MIN:    res_v = min_q;
      MODE_MAX:    res_v = max_q;
      default:     res_na = 1'b1;
    endcase
    if (n == '0) res_na = 1'b1;
    if (res_na) res_v = '0;
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) store_a[cnt_a_q[AW-1:0]] <= value_a_i;
    rda_q <= store_a[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) store_b[cnt_b_q[AW-1:0]] <= value_b_i;
    rdb_q <= store_b[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q   <= '0;
      cnt_b_q   <= '0;
      scan_q    <= 1'b0;
      med_q     <= 1'b0;
      run_q     <= 1'b0;
      p1_q      <= 1'b0;
      p1_cand_q <= 1'b0;
      p1_last_q <= 1'b0;
      p2_q      <= 1'b0;
      j_q       <= '0;
      i_q       <= '0;
      it_q      <= '0;
      uop_q     <= OP_NONE;
    end else begin
      if (cmd_i.op == OP_OUT) begin
        cnt_a_q <= '0;
        cnt_b_q <= '0;
      end else begin
        if (wr_a) cnt_a_q <= cnt_a_q + CW'(1);
        if (wr_b) cnt_b_q <= cnt_b_q + CW'(1);
      end
      p1_q      <= issue_acc || issue_med;
      p1_cand_q <= (j_q == '0);
      p1_last_q <= (j_q == n);
      p2_q      <= p1_q && scan_q;
      if (cmd_i.op == OP_ACC) begin
        scan_q <= 1'b1;
        j_q    <= '0;
      end else if (cmd_i.op == OP_MED) begin
        med_q <= 1'b1;
        j_q   <= '0;
        i_q   <= '0;
      end else begin
        if (issue_acc) j_q <= j_q + CW'(1);
        if (scan_q && !issue_acc && !p1_q && !p2_q) scan_q <= 1'b0;
        if (issue_med) begin
          if (j_q == n) begin
            j_q <= '0;
            i_q <= i_q + CW'(1);
          end else begin
            j_q <= j_q + CW'(1);
          end
        end
        if (med_q && !issue_med && !p1_q) med_q <= 1'b0;
      end
      unique case (cmd_i.op) inside
        OP_MUL_NS2, OP_MUL_S1SQ, OP_MUL_CV: begin
          run_q <= 1'b1;
          uop_q <= cmd_i.op;
          it_q  <= ITW'(SW - 1);
        end
        OP_DIV_MEAN, OP_DIV_VAR, OP_DIV_SD, OP_DIV_CV: begin
          run_q <= 1'b1;
          uop_q <= cmd_i.op;
          it_q  <= ITW'(NUMW - 1);
        end
        OP_SQRT: begin
          run_q <= 1'b1;
          uop_q <= cmd_i.op;
          it_q  <= ITW'(31);
        end
        default: begin
          if (run_q) begin
            if (it_q == '0) run_q <= 1'b0;
            else it_q <= it_q - ITW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_q) begin
      sqr_q <= x * x;
      x2_q  <= x;
    end
    if (cmd_i.op == OP_ACC) begin
      s1_q  <= '0;
      s2_q  <= '0;
      min_q <= 32'sh7fff_ffff;
      max_q <= 32'sh8000_0000;
    end else if (p2_q) begin
      s1_q <= s1_q + {{(SW-32){x2_q[31]}}, x2_q};
      s2_q <= s2_q + {{(WW-64){1'b0}}, sqr_q};
      if (x2_q < min_q) min_q <= x2_q;
      if (x2_q > max_q) max_q <= x2_q;
    end
    if (med_q && p1_q) begin
      if (p1_cand_q) begin
        c_q  <= x;
        lt_q <= '0;
        le_q <= '0;
      end else begin
        lt_q <= lt_n;
        le_q <= le_n;
        if (p1_last_q) begin
          if (lt_n <= k1 && k1 < le_n) lo_q <= c_q;
          if (lt_n <= k2 && k2 < le_n) hi_q <= c_q;
        end
      end
    end
    unique case (cmd_i.op)
      OP_MUL_NS2: begin
        acc_q <= '0;
        mc_q  <= s2_q;
        mp_q  <= SW'(n);
      end
      OP_MUL_S1SQ: begin
        d_q   <= acc_q;
        acc_q <= '0;
        mc_q  <= WW'(s1_mag);
        mp_q  <= s1_mag;
      end
      OP_MUL_CV: begin
        acc_q <= '0;
        mc_q  <= WW'(sd_r);
        mp_q  <= SW'(n);
      end
      OP_DIV_MEAN: begin
        num_q <= NUMW'(s1_mag) + NUMW'(n >> 1);
        den_q <= DENW'(n);
        rem_q <= '0;
      end
      OP_DIV_VAR: begin
        num_q <= NUMW'(dval) + (NUMW'(m) << 15);
        den_q <= DENW'(m) << 16;
        rem_q <= '0;
      end
      OP_DIV_SD: begin
        num_q <= NUMW'(dval);
        den_q <= DENW'(m);
        rem_q <= '0;
      end
      OP_DIV_CV: begin
        num_q <= (NUMW'(acc_q) << 16) + NUMW'(s1_mag >> 1);
        den_q <= DENW'(s1_mag);
        rem_q <= '0;
      end
      OP_SQRT: begin
        v_q   <= num_q[63:0];
        rt_q  <= '0;
        bit_q <= 64'h4000_0000_0000_0000;
      end
      OP_RESULT: begin
        if (cmd_i.ch) begin
          res_b_q <= res_v;
          na_b_q  <= res_na;
        end else begin
          res_a_q <= res_v;
          na_a_q  <= res_na;
        end
      end
      OP_OUT: begin
        out_a_q    <= res_a_q;
        out_na_a_q <= na_a_q;
        out_b_q    <= res_b_q;
        out_na_b_q <= na_b_q;
      end
      default: begin
        if (run_q) begin
          case (uop_q) inside
            OP_MUL_NS2, OP_MUL_S1SQ, OP_MUL_CV: begin
              if (mp_q[0]) acc_q <= acc_q + mc_q;
              mc_q <= mc_q << 1;
              mp_q <= mp_q >> 1;
            end
            OP_SQRT: begin
              if (v_q >= trial) begin
                v_q  <= v_q - trial;
                rt_q <= (rt_q >> 1) + bit_q;
              end else begin
                rt_q <= rt_q >> 1;
              end
              bit_q <= bit_q >> 2;
            end
            default: begin
              num_q <= num_nx;
              rem_q <= rem_nx;
            end
          endcase
        end
      end
    endcase
  end

  assign sts_o.busy     = scan_q || med_q || run_q;
  assign sts_o.n_zero   = (n == '0);
  assign sts_o.all_eq   = (min_q == max_q);
  assign sts_o.sum_zero = (s1_q == '0);

  assign stat_a_o = out_a_q;
  assign a_na_o   = out_na_a_q;
  assign stat_b_o = out_b_q;
  assign b_na_o   = out_na_b_q;

endmodule

// ===== hw/rtl/rgs_ctrl.sv =====
// controller: handshakes, mode register and sequencing of datapath operations
module rgs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  input  logic          s_last_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_data_i,
  output logic          cfg_ready_o,
  input  rgs_pkg::sts_t sts_i,
  output rgs_pkg::cmd_t cmd_o
);
  import rgs_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_ISSUE, S_WAIT, S_OUT} state_e;

  state_e     state_q;
  op_e        op_q, op_next;
  logic       ch_q, out_vld_q, out_wr;
  logic [2:0] mode_q;

  assign s_ready_o   = (state_q == S_LOAD);
  assign m_valid_o   = out_vld_q;
  assign cfg_ready_o = 1'b1;
  assign out_wr      = (state_q == S_OUT) && (!out_vld_q || m_ready_i);

  always_comb begin
    op_next = OP_RESULT;
    unique case (op_q)
      OP_ACC: begin
        if (sts_i.n_zero) op_next = OP_RESULT;
        else begin
          case (mode_q) inside
            MODE_MEAN:   op_next = OP_DIV_MEAN;
            MODE_MEDIAN: op_next = OP_MED;
            MODE_VAR, MODE_SD, MODE_CV:
              op_next = sts_i.all_eq ? OP_RESULT : OP_MUL_NS2;
            default:     op_next = OP_RESULT;
          endcase
        end
      end
      OP_MUL_NS2:  op_next = OP_MUL_S1SQ;
      OP_MUL_S1SQ: op_next = (mode_q == MODE_VAR) ? OP_DIV_VAR : OP_DIV_SD;
      OP_DIV_SD:   op_next = OP_SQRT;
      OP_SQRT:     op_next = (mode_q == MODE_CV && !sts_i.sum_zero) ? OP_MUL_CV : OP_RESULT;
      OP_MUL_CV:   op_next = OP_DIV_CV;
      default:     op_next = OP_RESULT;
    endcase
  end

  always_comb begin
    cmd_o.ch   = ch_q;
    cmd_o.mode = mode_q;
    if (state_q == S_ISSUE) cmd_o.op = op_q;
    else if (out_wr) cmd_o.op = OP_OUT;
    else cmd_o.op = OP_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_LOAD;
      op_q      <= OP_NONE;
      ch_q      <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= MODE_MEAN;
    end else begin
      if (cfg_valid_i) mode_q <= cfg_data_i;
      if (out_vld_q && m_ready_i && !out_wr) out_vld_q <= 1'b0;
      unique case (state_q)
        S_LOAD: begin
          if (s_valid_i && s_last_i) begin
            op_q    <= OP_ACC;
            ch_q    <= 1'b0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_WAIT;
        S_WAIT: begin
          if (!sts_i.busy) begin
            if (op_q == OP_RESULT) begin
              if (!ch_q) begin
                ch_q    <= 1'b1;
                op_q    <= OP_ACC;
                state_q <= S_ISSUE;
              end else begin
                state_q <= S_OUT;
              end
            end else begin
              op_q    <= op_next;
              state_q <= S_ISSUE;
            end
          end
        end
        S_OUT: begin
          if (out_wr) begin
            out_vld_q <= 1'b1;
            ch_q      <= 1'b0;
            state_q   <= S_LOAD;
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !sts_i.busy)
    else $error("datapath busy while loading");

  a_out_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside output state");

  a_load_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_LOAD |-> !ch_q)
    else $error("channel select not cleared");

endmodule

// ===== bench/tb.sv =====
// testbench for replicate_group_statistics: directed and random replicate groups checked against a predictor
`timescale 1ns / 1ps

class group_stats_board;
  typedef struct packed {
    logic [31:0] stat_a;
    logic        na_a;
    logic [31:0] stat_b;
    logic        na_b;
  } stats_t;

  logic signed [31:0] vals_a[16];
  logic signed [31:0] vals_b[16];
  int unsigned        n_a;
  int unsigned        n_b;
  logic [2:0]         mode;
  stats_t             pending_stats[$];
  int                 errors;
  int                 groups_seen;

  function void set_mode(logic [2:0] m);
    mode = m;
  endfunction

  function longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function longint sat(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function void channel(input logic signed [31:0] s[16], input int unsigned n,
                        output logic [31:0] stat, output logic na);
    longint             sum;
    longint             r;
    logic signed [31:0] t[16];
    logic signed [31:0] tmp;
    logic [127:0]       d;
    logic [127:0]       q;
    logic [63:0]        a;
    logic [63:0]        sq;
    longint             df;
    longint             m;
    stat = 0;
    na = 1;
    sum = 0;
    if (n == 0 || mode > rgs_pkg::MODE_MAX) return;
    for (int i = 0; i < n; i++) sum += s[i];
    case (mode) inside
      rgs_pkg::MODE_MEAN: r = round_div(sum, n);
      rgs_pkg::MODE_MEDIAN: begin
        t = s;
        for (int i = 0; i < n; i++)
          for (int j = 0; j + 1 < n - i; j++)
            if (t[j] > t[j+1]) begin
              tmp = t[j]; t[j] = t[j+1]; t[j+1] = tmp;
            end
        if (n % 2 == 0) r = round_div(longint'(t[n/2-1]) + longint'(t[n/2]), 2);
        else r = t[n/2];
      end
      rgs_pkg::MODE_MIN, rgs_pkg::MODE_MAX: begin
        r = s[0];
        for (int i = 1; i < n; i++)
          if (mode == rgs_pkg::MODE_MIN ? s[i] < r : s[i] > r) r = s[i];
      end
      default: begin
        d = 0;
        m = n * (n - 1);
        for (int i = 0; i < n; i++)
          for (int j = i + 1; j < n; j++) begin
            df = longint'(s[i]) - longint'(s[j]);
            a = df < 0 ? -df : df;
            d += {64'd0, a * a};
          end
        if (d == 0) return;
        if (mode == rgs_pkg::MODE_VAR) begin
          q = (d + (m << 15)) / (m << 16);
          r = q > 128'h7fff_ffff ? 64'sd2147483647 : longint'(q[63:0]);
        end else begin
          q = d / m;
          sq = int_sqrt(q[63:0]);
          if (q[63:0] - sq * sq > sq) sq++;
          if (mode == rgs_pkg::MODE_SD) begin
            r = sq > 64'h7fff_ffff ? 64'sd2147483647 : longint'(sq);
          end else begin
            if (sum == 0) return;
            r = sat(round_div(longint'((sq * n) << 16), sum < 0 ? -sum : sum));
            if (sum < 0) r = -r;
            r = sat(r);
          end
        end
      end
    endcase
    stat = r[31:0];
    na = 0;
  endfunction

  function void note_replicate(logic [31:0] va, logic ma, logic [31:0] vb, logic mb,
                               logic last);
    stats_t e;
    if (!ma && n_a < 16) begin vals_a[n_a] = va; n_a++; end
    if (!mb && n_b < 16) begin vals_b[n_b] = vb; n_b++; end
    if (!last) return;
    channel(vals_a, n_a, e.stat_a, e.na_a);
    channel(vals_b, n_b, e.stat_b, e.na_b);
    n_a = 0;
    n_b = 0;
    pending_stats = {pending_stats, e};
  endfunction

  function void check_stats(logic [31:0] sa, logic naa, logic [31:0] sb, logic nab);
    stats_t e;
    groups_seen++;
    if (pending_stats.size() == 0) begin
      $display("%0t: unexpected result a=%h/%b b=%h/%b", $time, sa, naa, sb, nab);
      errors++;
      return;
    end
    e = pending_stats.pop_front();
    if (e.stat_a !== sa) begin
      $display("%0t: stat_a expected %h actual %h", $time, e.stat_a, sa); errors++;
    end
    if (e.na_a !== naa) begin
      $display("%0t: a_not_available expected %b actual %b", $time, e.na_a, naa); errors++;
    end
    if (e.stat_b !== sb) begin
      $display("%0t: stat_b expected %h actual %h", $time, e.stat_b, sb); errors++;
    end
    if (e.na_b !== nab) begin
      $display("%0t: b_not_available expected %b actual %b", $time, e.na_b, nab); errors++;
    end
  endfunction
endclass

module tb;
  import rgs_pkg::*;

  localparam int StallLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [63:0] s_data;
  logic [1:0]  s_user;
  logic        s_last;
  logic        m_valid;
  logic        m_ready;
  logic [63:0] m_data;
  logic [1:0]  m_user;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_data;

  group_stats_board board;
  int  idle_pct;
  int  stall_pct;
  bit  hold_off;
  int  quiet_cycles;
  int  items_sent;
  logic signed [31:0] last_val;

  replicate_group_statistics u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user), .s_axis_tlast_i(s_last),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  always @(posedge clk) begin
    if (m_valid && m_ready)
      board.check_stats(m_data[31:0], m_user[0], m_data[63:32], m_user[1]);
    if ((m_valid && m_ready) || (s_valid && s_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("RESULT: ERROR");
      $finish;
    end
    m_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  function logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return last_val;
      2: return $signed($urandom_range(2000)) - 1000;
      3: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'h0} + $urandom_range(65535);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_replicate(logic [31:0] va, logic ma, logic [31:0] vb, logic mb,
                                logic last);
    if ($urandom_range(99) < idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    s_valid <= 1'b1;
    s_data <= {vb, va};
    s_user <= {mb, ma};
    s_last <= last;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    board.note_replicate(va, ma, vb, mb, last);
    items_sent++;
  endtask

  task automatic send_group(int n, int miss_pct, bit same);
    logic [31:0] va;
    logic [31:0] vb;
    for (int i = 0; i < n; i++) begin
      va = same && i > 0 ? va : pick_value();
      last_val = va;
      vb = same && i > 0 ? vb : pick_value();
      send_replicate(va, $urandom_range(99) < miss_pct, vb, $urandom_range(99) < miss_pct,
                     i == n - 1);
    end
  endtask

  task automatic write_mode(logic [2:0] m);
    s_valid <= 1'b0;
    @(posedge clk);
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.set_mode(m);
  endtask

  task automatic directed_groups();
    send_replicate(32'h7fff_ffff, 0, 32'h8000_0000, 0, 0);
    send_replicate(32'h8000_0000, 0, 32'h8000_0000, 0, 1);
    send_replicate(32'h0003_0000, 0, 32'h0, 1, 0);
    send_replicate(32'h0003_0000, 0, 32'h0, 1, 0);
    send_replicate(32'h0003_0000, 0, 32'h0, 1, 1);
    send_replicate(32'hfffd_0000, 0, 32'h0001_0000, 0, 0);
    send_replicate(32'h0003_0000, 0, 32'h0002_0000, 0, 1);
    send_replicate(32'h0000_0001, 0, 32'hffff_ffff, 0, 1);
    for (int i = 0; i < 18; i++)
      send_replicate(i * 32'h0001_1111, 0, 32'h8000_0000 - i, i[0], i == 17);
  endtask

  initial begin
    int idles[4];
    int stalls[4];
    board = new();
    board.set_mode(MODE_MEAN);
    idles = '{0, 51, 0, 6};
    stalls = '{0, 0, 51, 6};
    rst_n = 1'b0;
    s_valid = 1'b0; s_data = '0; s_user = '0; s_last = 1'b0;
    m_ready = 1'b0; cfg_valid = 1'b0; cfg_data = '0;
    idle_pct = 0; stall_pct = 0; hold_off = 0; quiet_cycles = 0;
    items_sent = 0; last_val = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_mode(MODE_CV);
    directed_groups();
    write_mode(MODE_VAR);
    directed_groups();

    for (int p = 0; p < 4; p++) begin
      idle_pct = idles[p];
      stall_pct = stalls[p];
      for (int md = 0; md < 8; md++) begin
        write_mode(md[2:0]);
        if (p == 2 && md == 0)
          fork
            begin
              hold_off = 1;
              repeat (400) @(posedge clk);
              hold_off = 0;
            end
          join_none
        for (int k = 0; k < 12; ) begin
          int n;
          n = $urandom_range(9) == 0 ? $urandom_range(20, 17) :
              (p == 2 && md == 0) ? $urandom_range(2, 1) : $urandom_range(16, 1);
          send_group(n, $urandom_range(9) == 0 ? 100 : ($urandom_range(1) ? 20 : 0),
                     $urandom_range(5) == 0);
          k += n;
        end
      end
    end

    s_valid <= 1'b0;
    while (board.pending_stats.size() != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    $display("sent %0d replicates, checked %0d group results over all eight modes",
             items_sent, board.groups_seen);
    $display("idle and stall mixes plus one long output hold-off were applied");
    if (board.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/rgs_pkg.sv
hw/rtl/rgs_dp.sv
hw/rtl/rgs_ctrl.sv
hw/rtl/replicate_group_statistics.sv
bench/tb.sv
